### hdl/wst_pkg.sv
// Shared types and constants for the wait statistics table.
// Request, result and internal command formats, status and command codes.
// No dependencies.
package wst_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int QUEUE_DEPTH       = 2;

	localparam int ADDR_W  = 48;
	localparam int TIME_W  = 64;
	localparam int COUNT_W = 32;
	localparam int KIND_W  = 2;
	localparam int INDEX_W = 6;
	localparam int USED_W  = 7;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_IGNORED  = 3'd3,
		ST_CLEARED  = 3'd4,
		ST_READ     = 3'd5
	} status_t;

	// operation decided by the front end
	typedef enum logic [2:0] {
		OP_IGNORE    = 3'd0,
		OP_RECORD    = 3'd1,
		OP_CLEAR     = 3'd2,
		OP_READ      = 3'd3,
		OP_READ_NONE = 3'd4
	} op_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [ADDR_W-1:0]  caller_address;
		logic [TIME_W-1:0]  start_time;
		logic [TIME_W-1:0]  end_time;
		logic [KIND_W-1:0]  event_type;
		logic [INDEX_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [ADDR_W-1:0]  entry_address;
		logic [KIND_W-1:0]  entry_kind;
		logic [COUNT_W-1:0] entry_count;
		logic [TIME_W-1:0]  entry_max_wait;
		logic [TIME_W-1:0]  entry_total_wait;
		logic [USED_W-1:0]  used_entries;
	} rsp_t;

	typedef struct packed {
		op_t                op;
		logic [ADDR_W-1:0]  addr;
		logic [TIME_W-1:0]  wait_time;
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] index;
	} desc_t;

	typedef struct packed {
		logic [ADDR_W-1:0] key;
		logic [KIND_W-1:0] kind;
	} key_ent_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  max_wait;
		logic [TIME_W-1:0]  total_wait;
	} stats_t;

endpackage

### hdl/wait_statistics_table.sv
// Wait statistics table, top level: front end, command queue, back end, result queue.
// The back-end scan reads one RAM entry per cycle until a hit or the last entry in use, and
// a clear zeroes the statistics of every entry in use; the back end handles one command at a
// time and takes the next from the command queue only after the last result has gone into
// the result queue. Asynchronous active-low reset empties the table at once through the fill
// count; no clearing pass, RAM contents are left as they are.
module wait_statistics_table
	import wst_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t req,
	output logic empty,
	input  logic pop,
	output rsp_t rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	logic  stats_enable_q;
	desc_t fe_desc;
	desc_t cq_desc;
	logic  cq_empty;
	logic  cq_pop;
	logic  rq_full;
	logic  rq_push;
	rsp_t  rq_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			stats_enable_q <= cfg_data;
		end
	end

	wst_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.req         (req),
		.stats_enable(stats_enable_q),
		.desc        (fe_desc)
	);

	wst_fifo #(
		.WIDTH($bits(desc_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (fe_desc),
		.full  (full),
		.pop   (cq_pop),
		.rdata (cq_desc),
		.empty (cq_empty)
	);

	wst_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cq_empty(cq_empty),
		.cq_desc (cq_desc),
		.cq_pop  (cq_pop),
		.rq_full (rq_full),
		.rq_push (rq_push),
		.rq_data (rq_data)
	);

	wst_fifo #(
		.WIDTH($bits(rsp_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rq_push),
		.wdata (rq_data),
		.full  (rq_full),
		.pop   (pop),
		.rdata (rsp),
		.empty (empty)
	);

endmodule

### hdl/wst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/wst_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
// Used for the command queue and the result queue. No dependencies.
module wst_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == NW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/wst_front.sv
// Front end: classifies an incoming request into a queued command.
// Works out the wait time and whether a record or read applies. Uses wst_pkg.
module wst_front
	import wst_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  req_t  req,
	input  logic  stats_enable,
	output desc_t desc
);

	localparam int EW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = (EW > INDEX_W) ? EW : INDEX_W;

	logic in_range;

	assign in_range = (IW'(req.entry_index) < IW'(TABLE_ENTRIES));

	always_comb begin
		desc.addr      = req.caller_address;
		desc.wait_time = req.end_time - req.start_time;
		desc.kind      = req.event_type;
		desc.index     = req.entry_index;
		case (req.cmd)
			CMD_RECORD: begin
				// address zero is never recorded
				desc.op = (stats_enable && (req.caller_address != '0)) ? OP_RECORD : OP_IGNORE;
			end
			CMD_CLEAR: begin
				desc.op = OP_CLEAR;
			end
			CMD_READ: begin
				desc.op = in_range ? OP_READ : OP_READ_NONE;
			end
			default: begin
				desc.op = OP_IGNORE;
			end
		endcase
	end

endmodule

### hdl/wst_back.sv
// Back end: sequencer over the key and statistics RAMs.
// Scans for a key, updates or inserts, clears and reads. Uses wst_pkg and wst_ram.
module wst_back
	import wst_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cq_empty,
	input  desc_t cq_desc,
	output logic  cq_pop,
	input  logic  rq_full,
	output logic  rq_push,
	output rsp_t  rq_data
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_UPD    = 7'b0000100,
		S_INSERT = 7'b0001000,
		S_CLEAR  = 7'b0010000,
		S_RDWAIT = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t        state_q;
	desc_t         cur_q;
	rsp_t          res_q;
	rsp_t          res_d;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] fill_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          key_we;
	logic [AW-1:0] key_waddr;
	key_ent_t      key_wdata;
	key_ent_t      key_rd;
	logic          st_we;
	logic [AW-1:0] st_waddr;
	stats_t        st_wdata;
	stats_t        st_rd;
	stats_t        st_upd;

	logic [IW-1:0] idx_ext;
	logic [AW-1:0] idx_a;
	logic          idx_live;
	logic          scan_hit;
	logic          scan_last;
	logic          is_full;

	assign idx_ext   = IW'(cq_desc.index);
	assign idx_a     = idx_ext[AW-1:0];
	// entries at or above the fill count are not in use and read as zero
	assign idx_live  = (CW'(idx_a) < fill_q);
	assign scan_hit  = (key_rd.key == cur_q.addr);
	assign scan_last = ((CW'(ptr_q) + 1'b1) == fill_q);
	assign is_full   = (fill_q == CW'(TABLE_ENTRIES));

	assign cq_pop  = (state_q == S_IDLE) && !cq_empty;
	assign rq_push = (state_q == S_EMIT) && !rq_full;

	always_comb begin
		rq_data              = res_q;
		rq_data.used_entries = USED_W'(fill_q);
	end

	always_comb begin
		st_upd.count      = st_rd.count + 1'b1;
		st_upd.max_wait   = (cur_q.wait_time > st_rd.max_wait) ? cur_q.wait_time : st_rd.max_wait;
		st_upd.total_wait = st_rd.total_wait + cur_q.wait_time;
	end

	// read port: one entry per cycle during the scan, data held while rd_en is low
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q + 1'b1;
		case (state_q)
			S_IDLE: begin
				if (!cq_empty) begin
					if (cq_desc.op == OP_RECORD && fill_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = '0;
					end else if (cq_desc.op == OP_READ && idx_live) begin
						rd_en   = 1'b1;
						rd_addr = idx_a;
					end
				end
			end
			S_SCAN: begin
				rd_en = !scan_hit && !scan_last;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		key_we         = (state_q == S_INSERT) && !is_full;
		key_waddr      = fill_q[AW-1:0];
		key_wdata.key  = cur_q.addr;
		key_wdata.kind = cur_q.kind;
		st_we          = 1'b0;
		st_waddr       = ptr_q;
		st_wdata       = '0;
		case (state_q)
			S_UPD: begin
				st_we    = 1'b1;
				st_wdata = st_upd;
			end
			S_INSERT: begin
				st_we               = !is_full;
				st_waddr            = fill_q[AW-1:0];
				st_wdata.count      = COUNT_W'(1);
				st_wdata.max_wait   = cur_q.wait_time;
				st_wdata.total_wait = cur_q.wait_time;
			end
			S_CLEAR: begin
				st_we = 1'b1;
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	wst_ram #(
		.WIDTH($bits(key_ent_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(key_rd)
	);

	wst_ram #(
		.WIDTH($bits(stats_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_stats_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(st_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!cq_empty) begin
						ptr_q <= '0;
						case (cq_desc.op)
							OP_RECORD: begin
								state_q <= (fill_q == '0) ? S_INSERT : S_SCAN;
							end
							OP_CLEAR: begin
								state_q <= (fill_q == '0) ? S_EMIT : S_CLEAR;
							end
							OP_READ: begin
								state_q <= idx_live ? S_RDWAIT : S_EMIT;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q <= S_UPD;
					end else if (scan_last) begin
						state_q <= S_INSERT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_UPD: begin
					state_q <= S_EMIT;
				end
				S_INSERT: begin
					if (!is_full) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_CLEAR: begin
					if (scan_last) begin
						state_q <= S_EMIT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_RDWAIT: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!rq_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res_d = res_q;
		case (state_q)
			S_IDLE: begin
				if (!cq_empty) begin
					res_d = '0;
					case (cq_desc.op)
						OP_IGNORE: begin
							res_d.status = ST_IGNORED;
						end
						OP_CLEAR: begin
							res_d.status = ST_CLEARED;
						end
						OP_READ, OP_READ_NONE: begin
							res_d.status = ST_READ;
						end
						default: begin
							res_d.status = ST_UPDATED;
						end
					endcase
				end
			end
			S_UPD: begin
				res_d.status           = ST_UPDATED;
				res_d.entry_address    = key_rd.key;
				res_d.entry_kind       = key_rd.kind;
				res_d.entry_count      = st_upd.count;
				res_d.entry_max_wait   = st_upd.max_wait;
				res_d.entry_total_wait = st_upd.total_wait;
			end
			S_INSERT: begin
				if (is_full) begin
					res_d.status = ST_FULL;
				end else begin
					res_d.status           = ST_INSERTED;
					res_d.entry_address    = cur_q.addr;
					res_d.entry_kind       = cur_q.kind;
					res_d.entry_count      = COUNT_W'(1);
					res_d.entry_max_wait   = cur_q.wait_time;
					res_d.entry_total_wait = cur_q.wait_time;
				end
			end
			S_RDWAIT: begin
				res_d.status           = ST_READ;
				res_d.entry_address    = key_rd.key;
				res_d.entry_kind       = key_rd.kind;
				res_d.entry_count      = st_rd.count;
				res_d.entry_max_wait   = st_rd.max_wait;
				res_d.entry_total_wait = st_rd.total_wait;
			end
			default: begin
				res_d = res_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && !cq_empty) begin
			cur_q <= cq_desc;
		end
		res_q <= res_d;
	end

`ifndef SYNTHESIS
	a_key_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (fill_q < CW'(TABLE_ENTRIES)))
		else $error("key written with the table full");

	a_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_CLEAR) |-> (CW'(ptr_q) < fill_q))
		else $error("scan pointer beyond filled entries");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fill_q) |-> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count moved by other than one");

	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |=> (state_q != S_IDLE))
		else $error("command taken but sequencer stayed idle");
`endif

endmodule
